>>> rtl/tsrl_pkg.sv
// ----------------------------------------------------------------------------
// tsrl_pkg
// Shared types and constants for the SYN rate limit filter.
// ----------------------------------------------------------------------------
package tsrl_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;

  localparam logic [3:0]  MIN_DATA_OFFSET = 4'd5;
  localparam logic [7:0]  THRESH_RST      = 8'd5;
  localparam logic [15:0] WINDOW_RST      = 16'd1000;
  localparam logic [7:0]  HITS_MAX        = 8'hFF;
  localparam logic [7:0]  HITS_FIRST      = 8'd1;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic REG_THRESH = 1'b0;
  localparam logic REG_WINDOW = 1'b1;

  localparam int FL_FIN = 0;
  localparam int FL_SYN = 1;
  localparam int FL_RST = 2;
  localparam int FL_PSH = 3;
  localparam int FL_ACK = 4;
  localparam int FL_URG = 5;

  typedef enum logic [2:0] {
    RSN_OK      = 3'd0,
    RSN_NO_HDR  = 3'd1,
    RSN_SHORT   = 3'd2,
    RSN_SYN_FIN = 3'd3,
    RSN_XMAS    = 3'd4,
    RSN_NULL    = 3'd5,
    RSN_RATE    = 3'd6
  } reason_t;

  typedef struct packed {
    logic        thr;
    logic        win;
  } cfg_sel_t;

  typedef struct packed {
    logic [7:0]  thr;
    logic [15:0] win;
  } cfg_t;

  typedef struct packed {
    logic        vld;
    logic        pend;
    logic [31:0] src;
    logic [31:0] now;
    logic        drop;
    reason_t     reason;
    logic        alert;
  } tok_t;

endpackage

>>> rtl/tsrl_in_if.sv
// ----------------------------------------------------------------------------
// tsrl_in_if
// Header summary channel: valid/ready handshake with the header fields.
// ----------------------------------------------------------------------------
interface tsrl_in_if;
  logic        valid;
  logic        ready;
  logic        ip_header_ok;
  logic        is_tcp;
  logic        tcp_header_ok;
  logic [3:0]  data_offset;
  logic [5:0]  tcp_flags;
  logic [31:0] source_ip;
  logic [31:0] now_ticks;

  modport source (
    output valid, ip_header_ok, is_tcp, tcp_header_ok, data_offset, tcp_flags,
           source_ip, now_ticks,
    input  ready
  );

  modport sink (
    input  valid, ip_header_ok, is_tcp, tcp_header_ok, data_offset, tcp_flags,
           source_ip, now_ticks,
    output ready
  );
endinterface

>>> rtl/tsrl_out_if.sv
// ----------------------------------------------------------------------------
// tsrl_out_if
// Verdict channel: valid/ready handshake with drop, reason and alert.
// ----------------------------------------------------------------------------
interface tsrl_out_if;
  logic       valid;
  logic       ready;
  logic       drop;
  logic [2:0] reason;
  logic       alert;

  modport source (
    output valid, drop, reason, alert,
    input  ready
  );

  modport sink (
    input  valid, drop, reason, alert,
    output ready
  );
endinterface

>>> rtl/tsrl_cfg.sv
// ----------------------------------------------------------------------------
// tsrl_cfg
// APB register file: rate threshold and window length.
// ----------------------------------------------------------------------------
module tsrl_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tsrl_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [tsrl_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [tsrl_pkg::CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  output tsrl_pkg::cfg_t             cfg
);
  import tsrl_pkg::*;

  logic [7:0]  thr_r;
  logic [7:0]  thr_nxt;
  logic [15:0] win_r;
  logic [15:0] win_nxt;
  logic        wr_en;
  logic        reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[2];

  always_comb begin
    thr_nxt = thr_r;
    win_nxt = win_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_THRESH: thr_nxt = pwdata[7:0];
        REG_WINDOW: win_nxt = pwdata[15:0];
        default:    thr_nxt = thr_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THRESH_RST;
      win_r <= WINDOW_RST;
    end else begin
      thr_r <= thr_nxt;
      win_r <= win_nxt;
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_THRESH: prdata = {24'd0, thr_r};
      REG_WINDOW: prdata = {16'd0, win_r};
      default:    prdata = '0;
    endcase
  end

  assign cfg.thr = thr_r;
  assign cfg.win = win_r;

endmodule

>>> rtl/tsrl_check.sv
// ----------------------------------------------------------------------------
// tsrl_check
// Header sanity checks; launch a transaction into the tracking chain.
// ----------------------------------------------------------------------------
module tsrl_check (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  tsrl_in_if.sink           in_chan,
  output tsrl_pkg::tok_t    tok_o
);
  import tsrl_pkg::*;

  tok_t tok_r;
  tok_t tok_nxt;
  logic [5:0] fl;

  assign fl = in_chan.tcp_flags;

  always_comb begin
    tok_nxt        = '0;
    tok_nxt.vld    = in_chan.valid;
    tok_nxt.src    = in_chan.source_ip;
    tok_nxt.now    = in_chan.now_ticks;
    tok_nxt.reason = RSN_OK;
    priority if (!in_chan.ip_header_ok) begin
      tok_nxt.drop   = 1'b1;
      tok_nxt.reason = RSN_NO_HDR;
    end else if (!in_chan.is_tcp) begin
      tok_nxt.drop   = 1'b0;
    end else if (!in_chan.tcp_header_ok) begin
      tok_nxt.drop   = 1'b1;
      tok_nxt.reason = RSN_NO_HDR;
    end else if (in_chan.data_offset < MIN_DATA_OFFSET) begin
      tok_nxt.drop   = 1'b1;
      tok_nxt.reason = RSN_SHORT;
    end else if (fl[FL_SYN] && fl[FL_FIN]) begin
      tok_nxt.drop   = 1'b1;
      tok_nxt.reason = RSN_SYN_FIN;
      tok_nxt.alert  = 1'b1;
    end else if (fl[FL_FIN] && fl[FL_URG] && fl[FL_PSH]) begin
      tok_nxt.drop   = 1'b1;
      tok_nxt.reason = RSN_XMAS;
      tok_nxt.alert  = 1'b1;
    end else if (fl == 6'd0) begin
      tok_nxt.drop   = 1'b1;
      tok_nxt.reason = RSN_NULL;
      tok_nxt.alert  = 1'b1;
    end else if (fl[FL_SYN] && !fl[FL_ACK]) begin
      tok_nxt.pend   = 1'b1;
    end else begin
      tok_nxt.drop   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else if (adv) begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

>>> rtl/tsrl_cell.sv
// ----------------------------------------------------------------------------
// tsrl_cell
// One table entry of the source chain: match, count, insert, pass on.
// ----------------------------------------------------------------------------
module tsrl_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  tsrl_pkg::cfg_t cfg,
  input  tsrl_pkg::tok_t tok_i,
  output tsrl_pkg::tok_t tok_o
);
  import tsrl_pkg::*;

  logic        vld_r;
  logic        vld_nxt;
  logic [31:0] src_r;
  logic [31:0] src_nxt;
  logic [31:0] start_r;
  logic [31:0] start_nxt;
  logic [7:0]  hits_r;
  logic [7:0]  hits_nxt;
  logic        alerted_r;
  logic        alerted_nxt;
  tok_t        tok_r;
  tok_t        tok_nxt;

  logic        hit;
  logic [31:0] diff;
  logic [7:0]  hits_inc;

  assign hit      = vld_r && (src_r == tok_i.src);
  assign diff     = tok_i.now - (start_r + {16'd0, cfg.win});
  assign hits_inc = (hits_r == HITS_MAX) ? hits_r : hits_r + 8'd1;

  always_comb begin
    tok_nxt     = tok_i;
    vld_nxt     = vld_r;
    src_nxt     = src_r;
    start_nxt   = start_r;
    hits_nxt    = hits_r;
    alerted_nxt = alerted_r;
    if (adv && tok_i.vld && tok_i.pend) begin
      priority if (hit) begin
        tok_nxt.pend = 1'b0;
        if (diff[31]) begin
          hits_nxt = hits_inc;
          if (hits_inc > cfg.thr) begin
            tok_nxt.drop   = 1'b1;
            tok_nxt.reason = RSN_RATE;
            tok_nxt.alert  = !alerted_r;
            alerted_nxt    = 1'b1;
          end
        end else begin
          start_nxt   = tok_i.now;
          hits_nxt    = HITS_FIRST;
          alerted_nxt = 1'b0;
        end
      end else if (!vld_r) begin
        tok_nxt.pend = 1'b0;
        vld_nxt      = 1'b1;
        src_nxt      = tok_i.src;
        start_nxt    = tok_i.now;
        hits_nxt     = HITS_FIRST;
        alerted_nxt  = 1'b0;
      end else begin
        tok_nxt.pend = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= 1'b0;
      tok_r.vld <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      if (adv) begin
        tok_r <= tok_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    src_r     <= src_nxt;
    start_r   <= start_nxt;
    hits_r    <= hits_nxt;
    alerted_r <= alerted_nxt;
  end

  assign tok_o = tok_r;

endmodule

>>> rtl/tcp_syn_rate_limit_filter_top.sv
// ----------------------------------------------------------------------------
// tcp_syn_rate_limit_filter_top
// Per-source SYN rate limiter with TCP flag sanity checks.
//
// in_chan carries one header summary per transaction; out_chan returns one
// verdict (drop, reason, alert) per transaction, in arrival order. Both use a
// valid/ready handshake. The APB port sets rate_threshold (0x0) and
// window_ticks (0x4); pready is always high.
// Each transaction passes a check stage, then a chain of TABLE_ENTRIES cells,
// one source entry each, moving one cell per cycle unless stalled, then the
// output register. Throughput is one transaction a cycle unless stalled,
// since later transactions follow one cell behind and see every update.
// A stalled receiver holds the output register and freezes the whole chain;
// in_chan.ready falls until the verdict is taken.
// Reset empties the table and the chain and loads the register defaults
// (threshold 5, window 1000). The table fills in arrival order; once full,
// new sources are accepted untracked.
// ----------------------------------------------------------------------------
module tcp_syn_rate_limit_filter_top #(
  parameter int TABLE_ENTRIES = tsrl_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  tsrl_in_if.sink                         in_chan,
  tsrl_out_if.source                      out_chan,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tsrl_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [tsrl_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [tsrl_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import tsrl_pkg::*;

  cfg_t       cfg;
  logic       adv;
  tok_t       chain [TABLE_ENTRIES+1];
  logic       out_vld_r;
  logic       drop_r;
  reason_t    reason_r;
  logic       alert_r;

  assign adv           = !out_vld_r || out_chan.ready;
  assign in_chan.ready = adv;

  tsrl_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tsrl_check u_check (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_chan (in_chan),
    .tok_o   (chain[0])
  );

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    tsrl_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .cfg   (cfg),
      .tok_i (chain[g]),
      .tok_o (chain[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= chain[TABLE_ENTRIES].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      drop_r   <= chain[TABLE_ENTRIES].drop;
      reason_r <= chain[TABLE_ENTRIES].reason;
      alert_r  <= chain[TABLE_ENTRIES].alert;
    end
  end

  assign out_chan.valid  = out_vld_r;
  assign out_chan.drop   = drop_r;
  assign out_chan.reason = reason_r;
  assign out_chan.alert  = alert_r;

endmodule

>>> test/tcp_syn_rate_limit_filter_top_tb.sv
// ----------------------------------------------------------------------------
// tcp_syn_rate_limit_filter_top_tb
// Self-checking bench for the SYN rate limit filter. A queue-fed driver sends
// header summaries and an in-order scoreboard checks every verdict against a
// behavioural copy of the check chain and source table. Runs a directed pass
// at reset defaults, then random phases across threshold and window settings,
// including zero window, saturated threshold, hit-count saturation and a full
// table, with random gaps on both handshakes.
// ----------------------------------------------------------------------------
module tcp_syn_rate_limit_filter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tsrl_pkg::*;

  localparam int TBL_DEPTH    = TABLE_ENTRIES_DEF;
  localparam int DRAIN_CYCLES = TBL_DEPTH + 8;
  localparam int QUIET_LIMIT  = 4000;
  localparam int POOL_SIZE    = 100;

  localparam logic [5:0] F_FIN = 6'(1 << FL_FIN);
  localparam logic [5:0] F_SYN = 6'(1 << FL_SYN);
  localparam logic [5:0] F_RST = 6'(1 << FL_RST);
  localparam logic [5:0] F_PSH = 6'(1 << FL_PSH);
  localparam logic [5:0] F_ACK = 6'(1 << FL_ACK);
  localparam logic [5:0] F_URG = 6'(1 << FL_URG);
  localparam logic [5:0] XMAS_MASK = F_FIN | F_PSH | F_URG;

  typedef struct packed {
    logic        ip_ok;
    logic        tcp;
    logic        tcp_ok;
    logic [3:0]  doff;
    logic [5:0]  flags;
    logic [31:0] src;
    logic [31:0] now;
  } hdr_t;

  typedef struct packed {
    logic    drop;
    reason_t reason;
    logic    alert;
  } verdict_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid  = 1'b0;
  hdr_t                  in_hdr    = '0;
  logic                  out_ready = 1'b0;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr     = '0;
  logic [CFG_DATA_W-1:0] pwdata    = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  hdr_t     pending_headers[$];
  verdict_t expected_verdicts[$];

  logic [7:0]  thr_cfg = THRESH_RST;
  logic [15:0] win_cfg = WINDOW_RST;

  bit          tbl_valid   [TBL_DEPTH];
  logic [31:0] tbl_src     [TBL_DEPTH];
  logic [31:0] tbl_start   [TBL_DEPTH];
  logic [7:0]  tbl_hits    [TBL_DEPTH];
  bit          tbl_alerted [TBL_DEPTH];
  int          tbl_used = 0;

  logic [31:0] src_pool [POOL_SIZE];
  logic [31:0] tick_now;
  bit          steady_flow = 1'b0;
  int          mismatches = 0;
  int          quiet_cycles = 0;

  tsrl_in_if  hdr_if ();
  tsrl_out_if verdict_if ();

  assign hdr_if.valid         = in_valid;
  assign hdr_if.ip_header_ok  = in_hdr.ip_ok;
  assign hdr_if.is_tcp        = in_hdr.tcp;
  assign hdr_if.tcp_header_ok = in_hdr.tcp_ok;
  assign hdr_if.data_offset   = in_hdr.doff;
  assign hdr_if.tcp_flags     = in_hdr.flags;
  assign hdr_if.source_ip     = in_hdr.src;
  assign hdr_if.now_ticks     = in_hdr.now;
  assign verdict_if.ready     = out_ready;

  tcp_syn_rate_limit_filter_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (hdr_if),
    .out_chan (verdict_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #1 clk = ~clk;

  function automatic verdict_t judge_header(input hdr_t h);
    verdict_t    v;
    logic [31:0] gap;
    int          slot;
    bit          found;
    v.drop   = 1'b0;
    v.reason = RSN_OK;
    v.alert  = 1'b0;
    found    = 1'b0;
    if (!h.ip_ok) begin
      v.drop   = 1'b1;
      v.reason = RSN_NO_HDR;
    end else if (!h.tcp) begin
      v.drop = 1'b0;
    end else if (!h.tcp_ok) begin
      v.drop   = 1'b1;
      v.reason = RSN_NO_HDR;
    end else if (h.doff < MIN_DATA_OFFSET) begin
      v.drop   = 1'b1;
      v.reason = RSN_SHORT;
    end else if (h.flags[FL_SYN] && h.flags[FL_FIN]) begin
      v.drop   = 1'b1;
      v.reason = RSN_SYN_FIN;
      v.alert  = 1'b1;
    end else if ((h.flags & XMAS_MASK) == XMAS_MASK) begin
      v.drop   = 1'b1;
      v.reason = RSN_XMAS;
      v.alert  = 1'b1;
    end else if (h.flags == 6'd0) begin
      v.drop   = 1'b1;
      v.reason = RSN_NULL;
      v.alert  = 1'b1;
    end else if (h.flags[FL_SYN] && !h.flags[FL_ACK]) begin
      for (slot = 0; slot < TBL_DEPTH; slot++) begin
        if (!found && tbl_valid[slot] && tbl_src[slot] == h.src) begin
          found = 1'b1;
          gap = h.now - (tbl_start[slot] + {16'h0, win_cfg});
          if (gap[31]) begin
            if (tbl_hits[slot] != HITS_MAX) tbl_hits[slot] = tbl_hits[slot] + 8'd1;
            if (tbl_hits[slot] > thr_cfg) begin
              v.drop             = 1'b1;
              v.reason           = RSN_RATE;
              v.alert            = !tbl_alerted[slot];
              tbl_alerted[slot]  = 1'b1;
            end
          end else begin
            tbl_start[slot]   = h.now;
            tbl_hits[slot]    = HITS_FIRST;
            tbl_alerted[slot] = 1'b0;
          end
        end
      end
      if (!found && tbl_used < TBL_DEPTH) begin
        tbl_valid[tbl_used]   = 1'b1;
        tbl_src[tbl_used]     = h.src;
        tbl_start[tbl_used]   = h.now;
        tbl_hits[tbl_used]    = HITS_FIRST;
        tbl_alerted[tbl_used] = 1'b0;
        tbl_used++;
      end
    end
    return v;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && hdr_if.ready) begin
        expected_verdicts.push_back(judge_header(in_hdr));
      end
      if (!in_valid || hdr_if.ready) begin
        if (pending_headers.size() != 0 && (steady_flow || $urandom_range(0, 99) >= 8)) begin
          in_hdr   <= pending_headers.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (verdict_if.valid && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          $display("%0t: unexpected verdict drop %0b reason %0d alert %0b", $time,
                   verdict_if.drop, verdict_if.reason, verdict_if.alert);
          mismatches++;
        end else begin
          want = expected_verdicts.pop_front();
          if (verdict_if.drop !== want.drop) begin
            $display("%0t: drop expected %0b actual %0b", $time, want.drop, verdict_if.drop);
            mismatches++;
          end
          if (verdict_if.reason !== want.reason) begin
            $display("%0t: reason expected %0d actual %0d", $time, want.reason,
                     verdict_if.reason);
            mismatches++;
          end
          if (verdict_if.alert !== want.alert) begin
            $display("%0t: alert expected %0b actual %0b", $time, want.alert,
                     verdict_if.alert);
            mismatches++;
          end
        end
      end
      out_ready <= steady_flow || $urandom_range(0, 99) >= 8;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && hdr_if.ready) || (verdict_if.valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("tcp_syn_rate_limit_filter_top_tb: errors");
        $finish;
      end
    end
  end

  task automatic cfg_write(input logic sel, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (sel == REG_THRESH) thr_cfg = value[7:0];
    else win_cfg = value[15:0];
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_headers.size() != 0 || in_valid || expected_verdicts.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic queue_header(input logic ip, input logic tcp, input logic tcp_ok,
                              input logic [3:0] doff, input logic [5:0] flags,
                              input logic [31:0] src, input logic [31:0] now);
    hdr_t h;
    h.ip_ok  = ip;
    h.tcp    = tcp;
    h.tcp_ok = tcp_ok;
    h.doff   = doff;
    h.flags  = flags;
    h.src    = src;
    h.now    = now;
    pending_headers.push_back(h);
  endtask

  task automatic run_phase(input int thr, input int win, input int count, input int lo,
                           input int hi, input int step_max, input int wf_pct,
                           input bit steady);
    hdr_t h;
    int   k;
    wait_drained();
    cfg_write(REG_THRESH, 32'(thr));
    cfg_write(REG_WINDOW, 32'(win));
    steady_flow = steady;
    for (k = 0; k < count; k++) begin
      tick_now = tick_now + 32'($urandom_range(0, step_max));
      if ($urandom_range(0, 99) < wf_pct) begin
        h.ip_ok  = 1'b1;
        h.tcp    = 1'b1;
        h.tcp_ok = 1'b1;
        h.doff   = 4'($urandom_range(5, 15));
        h.flags  = F_SYN | (6'($urandom) & (F_RST | F_PSH | F_URG));
        h.src    = src_pool[$urandom_range(lo, hi)];
        h.now    = tick_now;
      end else begin
        h.ip_ok  = $urandom_range(0, 7) != 0;
        h.tcp    = $urandom_range(0, 7) != 0;
        h.tcp_ok = $urandom_range(0, 7) != 0;
        h.doff   = 4'($urandom_range(0, 15));
        h.flags  = 6'($urandom_range(0, 63));
        h.src    = $urandom_range(0, 1) ? src_pool[$urandom_range(lo, hi)] : $urandom;
        h.now    = $urandom_range(0, 1) ? tick_now : $urandom;
      end
      pending_headers.push_back(h);
    end
  endtask

  initial begin
    logic [31:0] base;
    int          k;
    base = 32'hFFFF_FF00;
    src_pool[0] = 32'h0000_0000;
    src_pool[1] = 32'hFFFF_FFFF;
    for (k = 2; k < POOL_SIZE; k++) src_pool[k] = $urandom;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    queue_header(1'b0, 1'b1, 1'b1, 4'd15, 6'h3F, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_header(1'b1, 1'b0, 1'b1, 4'd15, F_SYN, 32'hFFFF_FFFF, base);
    queue_header(1'b1, 1'b1, 1'b0, 4'd15, F_SYN, 32'hFFFF_FFFF, base);
    queue_header(1'b1, 1'b1, 1'b1, 4'd0, F_SYN, 32'hFFFF_FFFF, base);
    queue_header(1'b1, 1'b1, 1'b1, 4'd4, F_SYN, 32'hFFFF_FFFF, base);
    queue_header(1'b1, 1'b1, 1'b1, 4'd5, F_SYN | F_FIN, 32'hFFFF_FFFF, base);
    queue_header(1'b1, 1'b1, 1'b1, 4'd5, XMAS_MASK, 32'hFFFF_FFFF, base);
    queue_header(1'b1, 1'b1, 1'b1, 4'd5, XMAS_MASK | F_RST | F_ACK, 32'hFFFF_FFFF, base);
    queue_header(1'b1, 1'b1, 1'b1, 4'd5, 6'h00, 32'hFFFF_FFFF, base);
    queue_header(1'b1, 1'b1, 1'b1, 4'd15, 6'h3F, 32'hFFFF_FFFF, base);
    queue_header(1'b1, 1'b1, 1'b1, 4'd5, F_SYN | F_ACK, 32'hFFFF_FFFF, base);
    queue_header(1'b1, 1'b1, 1'b1, 4'd5, F_ACK, 32'hFFFF_FFFF, base);
    queue_header(1'b1, 1'b1, 1'b1, 4'd5, F_RST, 32'hFFFF_FFFF, base);
    for (k = 0; k < 7; k++)
      queue_header(1'b1, 1'b1, 1'b1, 4'd5, F_SYN, 32'hFFFF_FFFF, base + 32'(k));
    queue_header(1'b1, 1'b1, 1'b1, 4'd5, F_SYN, 32'hFFFF_FFFF, base + 32'd999);
    queue_header(1'b1, 1'b1, 1'b1, 4'd5, F_SYN, 32'hFFFF_FFFF, base + 32'd1000);
    queue_header(1'b1, 1'b1, 1'b1, 4'd15, F_SYN | F_RST | F_PSH | F_URG,
                 32'h0000_0000, 32'h0000_0000);
    queue_header(1'b1, 1'b1, 1'b1, 4'd15, F_SYN, 32'h0000_0000, 32'hFFFF_FFFF);

    tick_now = base + 32'd2000;
    run_phase(2, 100, 40, 0, 7, 30, 80, 1'b0);
    run_phase(0, 1, 20, 0, 7, 2, 80, 1'b0);
    run_phase(5, 0, 20, 0, 7, 3, 80, 1'b0);
    run_phase(255, 65535, 258, 8, 8, 1, 100, 1'b1);
    run_phase(254, 65535, 10, 8, 8, 1, 100, 1'b0);
    run_phase($urandom_range(1, 6), $urandom_range(1, 2000), 120, 0, POOL_SIZE - 1, 200,
              80, 1'b0);
    run_phase(1, 500, 50, 0, POOL_SIZE - 1, 60, 80, 1'b0);

    wait_drained();
    if (mismatches == 0) begin
      $display("tcp_syn_rate_limit_filter_top_tb: clean");
    end else begin
      $display("tcp_syn_rate_limit_filter_top_tb: errors");
    end
    $finish;
  end

endmodule

>>> tcp_syn_rate_limit_filter_top.f
rtl/tsrl_pkg.sv
rtl/tsrl_in_if.sv
rtl/tsrl_out_if.sv
rtl/tsrl_cfg.sv
rtl/tsrl_check.sv
rtl/tsrl_cell.sv
rtl/tcp_syn_rate_limit_filter_top.sv
test/tcp_syn_rate_limit_filter_top_tb.sv
